// ===== hw/rtl/hdmlp_pkg.sv =====
`timescale 1ns / 1ps
// Package for the HID descriptor mouse layout parser.
// Item codes, tags, usage constants and shared types; no dependencies.
package hdmlp_pkg;

  // Item types from the short-item prefix
  localparam logic [1:0] ITEM_MAIN   = 2'd0;
  localparam logic [1:0] ITEM_GLOBAL = 2'd1;
  localparam logic [1:0] ITEM_LOCAL  = 2'd2;

  // Tags
  localparam logic [3:0] TAG_USAGE_PAGE   = 4'h0;
  localparam logic [3:0] TAG_REPORT_SIZE  = 4'h7;
  localparam logic [3:0] TAG_REPORT_ID    = 4'h8;
  localparam logic [3:0] TAG_REPORT_COUNT = 4'h9;
  localparam logic [3:0] TAG_USAGE        = 4'h0;
  localparam logic [3:0] TAG_USAGE_MIN    = 4'h1;
  localparam logic [3:0] TAG_USAGE_MAX    = 4'h2;
  localparam logic [3:0] TAG_INPUT        = 4'h8;

  localparam logic [7:0]  PFX_LONG      = 8'hFE;
  localparam logic [15:0] PAGE_DESKTOP  = 16'h0001;
  localparam logic [15:0] PAGE_BUTTON   = 16'h0009;
  localparam logic [15:0] USAGE_X       = 16'h0030;
  localparam logic [15:0] USAGE_Y       = 16'h0031;
  localparam logic [15:0] USAGE_WHEEL   = 16'h0038;
  localparam logic [16:0] POS_ABSENT    = 17'h1FFFF;
  localparam logic [15:0] SAT_MAX       = 16'hFFFF;

  // Byte decoder phases
  typedef enum logic [4:0] {
    PH_PREFIX    = 5'b00001,
    PH_SHORT     = 5'b00010,
    PH_LONG_SIZE = 5'b00100,
    PH_LONG_TAG  = 5'b01000,
    PH_LONG_SKIP = 5'b10000
  } phase_t;

  // One decoded short item
  typedef struct packed {
    logic        done;
    logic [1:0]  kind;
    logic [3:0]  tag;
    logic [31:0] value;
  } item_t;

  function automatic logic [15:0] sat16(input logic [32:0] v);
    return (v > 33'(SAT_MAX)) ? SAT_MAX : v[15:0];
  endfunction

endpackage

// ===== hw/rtl/hdmlp_in_if.sv =====
`timescale 1ns / 1ps
// Request channel carrying descriptor bytes.
// Standalone; no dependencies.
interface hdmlp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] desc_byte;
  logic       last_byte;

  modport source (output valid, output desc_byte, output last_byte, input ready);
  modport sink (input valid, input desc_byte, input last_byte, output ready);
endinterface

// ===== hw/rtl/hdmlp_out_if.sv =====
`timescale 1ns / 1ps
// Result channel carrying the mouse layout.
// Standalone; no dependencies.
interface hdmlp_out_if;
  logic               valid;
  logic               ready;
  logic               layout_valid;
  logic [7:0]         layout_report_id;
  logic               uses_report_id;
  logic signed [16:0] x_position;
  logic [15:0]        x_width;
  logic signed [16:0] y_position;
  logic [15:0]        y_width;
  logic signed [16:0] wheel_position;
  logic [15:0]        wheel_width;
  logic signed [16:0] buttons_position;
  logic [15:0]        buttons_number;

  modport source (
    output valid, input ready,
    output layout_valid, output layout_report_id, output uses_report_id,
    output x_position, output x_width, output y_position, output y_width,
    output wheel_position, output wheel_width,
    output buttons_position, output buttons_number
  );
  modport sink (
    input valid, output ready,
    input layout_valid, input layout_report_id, input uses_report_id,
    input x_position, input x_width, input y_position, input y_width,
    input wheel_position, input wheel_width,
    input buttons_position, input buttons_number
  );
endinterface

// ===== hw/rtl/hdmlp_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Standalone; no dependencies.
module hdmlp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/hdmlp_item_dec.sv =====
`timescale 1ns / 1ps
// Byte-level item decoder: assembles short items, skips long items.
// Depends on hdmlp_pkg.
module hdmlp_item_dec
  import hdmlp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic       clr,
  input  logic [7:0] byte_in,
  output item_t      item
);
  phase_t      phase_r, phase_nxt;
  logic [7:0]  prefix_r, prefix_nxt;
  logic [31:0] data_r, data_nxt;
  logic [2:0]  left_r, left_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [7:0]  skip_r, skip_nxt;
  logic [7:0]  skip_dec;

  always_comb begin
    phase_nxt  = phase_r;
    prefix_nxt = prefix_r;
    data_nxt   = data_r;
    left_nxt   = left_r;
    idx_nxt    = idx_r;
    skip_nxt   = skip_r;
    skip_dec   = (skip_r != 8'd0) ? skip_r - 8'd1 : skip_r;
    item       = '0;
    if (take) begin
      case (phase_r)
        PH_PREFIX: begin
          if (byte_in == PFX_LONG) begin
            phase_nxt = PH_LONG_SIZE;
          end else if (byte_in[1:0] == 2'd0) begin
            item.done = 1'b1;
            item.kind = byte_in[3:2];
            item.tag  = byte_in[7:4];
          end else begin
            prefix_nxt = byte_in;
            data_nxt   = '0;
            idx_nxt    = '0;
            left_nxt   = (byte_in[1:0] == 2'd3) ? 3'd4 : {1'b0, byte_in[1:0]};
            phase_nxt  = PH_SHORT;
          end
        end
        PH_SHORT: begin
          data_nxt[8*idx_r +: 8] = byte_in;
          idx_nxt  = idx_r + 2'd1;
          left_nxt = left_r - 3'd1;
          if (left_r == 3'd1) begin
            item.done  = 1'b1;
            item.kind  = prefix_r[3:2];
            item.tag   = prefix_r[7:4];
            item.value = data_nxt;
            phase_nxt  = PH_PREFIX;
          end
        end
        PH_LONG_SIZE: begin
          skip_nxt  = byte_in;
          phase_nxt = PH_LONG_TAG;
        end
        PH_LONG_TAG: begin
          phase_nxt = (skip_r == 8'd0) ? PH_PREFIX : PH_LONG_SKIP;
        end
        PH_LONG_SKIP: begin
          skip_nxt = skip_dec;
          if (skip_dec == 8'd0) begin
            phase_nxt = PH_PREFIX;
          end
        end
        default: phase_nxt = PH_PREFIX;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      phase_r  <= PH_PREFIX;
      prefix_r <= '0;
      data_r   <= '0;
      left_r   <= '0;
      idx_r    <= '0;
      skip_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      prefix_r <= prefix_nxt;
      data_r   <= data_nxt;
      left_r   <= left_nxt;
      idx_r    <= idx_nxt;
      skip_r   <= skip_nxt;
    end
  end
endmodule

// ===== hw/rtl/hid_descriptor_mouse_layout_parser_top.sv =====
`timescale 1ns / 1ps
// A non-constant Input item with nonzero size and count walks n = min(report count,
// MAX_FIELDS) fields through BASE, WALK_RD/WALK_EV per field and FINISH, one usage-RAM read per field.
// Other Input items go from BASE straight to FINISH. The last byte loads the result via EMIT.
// Per-ID bit offsets live in a RAM; one valid flop per entry clears at once.
// Reset (synchronous, rst_n low) and each emitted layout return the parse state and layout flags to empty.
module hid_descriptor_mouse_layout_parser_top
  import hdmlp_pkg::*;
#(
  parameter int USAGE_SLOTS = 16,
  parameter int REPORT_IDS  = 256,
  parameter int MAX_FIELDS  = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  hdmlp_in_if.sink  in_if,
  hdmlp_out_if.source out_if
);
  localparam int UA_W   = (USAGE_SLOTS > 1) ? $clog2(USAGE_SLOTS) : 1;
  localparam int FILL_W = $clog2(USAGE_SLOTS + 1);
  localparam int ID_W   = (REPORT_IDS > 1) ? $clog2(REPORT_IDS) : 1;
  localparam logic [15:0] MAX_F = 16'(MAX_FIELDS);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_BASE    = 6'b000010,
    ST_WALK_RD = 6'b000100,
    ST_WALK_EV = 6'b001000,
    ST_FINISH  = 6'b010000,
    ST_EMIT    = 6'b100000
  } state_t;

  function automatic logic [ID_W-1:0] id_index(input logic [7:0] id);
    logic [ID_W-1:0] r;
    r = '0;
    for (int k = 0; k < 256; k++) begin
      if (id == 8'(k)) r = ID_W'(k % REPORT_IDS);
    end
    return r;
  endfunction

  state_t st_r, st_nxt;
  item_t  item;
  logic   in_take, emit_load;

  // Globals and locals
  logic [15:0] page_r, page_nxt, size_r, size_nxt, count_r, count_nxt;
  logic [7:0]  id_r, id_nxt;
  logic        uses_id_r, uses_id_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic        rng_seen_r, rng_seen_nxt;
  logic [15:0] rng_lo_r, rng_lo_nxt, rng_hi_r, rng_hi_nxt;
  logic        last_pend_r, last_pend_nxt, const_r, const_nxt;
  logic [ID_W-1:0] ofs_idx_r, ofs_idx_nxt;
  logic [REPORT_IDS-1:0] ofs_vld_r, ofs_vld_nxt;

  // Walk datapath
  logic [15:0] base_r, base_nxt, pos_r, pos_nxt, wi_r, wi_nxt, wn_r, wn_nxt;
  logic [31:0] prod_r, prod_nxt;

  // Layout record
  logic [15:0] x_pos_r, x_pos_nxt, x_w_r, x_w_nxt, y_pos_r, y_pos_nxt, y_w_r, y_w_nxt;
  logic [15:0] wh_pos_r, wh_pos_nxt, wh_w_r, wh_w_nxt, bt_pos_r, bt_pos_nxt, bt_n_r, bt_n_nxt;
  logic        x_f_r, x_f_nxt, y_f_r, y_f_nxt, wh_f_r, wh_f_nxt, bt_f_r, bt_f_nxt;
  logic [7:0]  rid_r, rid_nxt;

  // Memory ports
  logic            u_we, o_we;
  logic [UA_W-1:0] u_waddr, u_raddr;
  logic [15:0]     u_rdata, o_rdata, o_wdata;
  logic [ID_W-1:0] o_raddr;
  logic            wi_lt_fill;
  logic [15:0]     usage;
  logic [16:0]     pos_sum, wi_inc;
  logic [32:0]     ofs_sum;

  // Output register
  logic        out_valid_r;
  logic        o_lv_r, o_uses_r;
  logic [7:0]  o_rid_r;
  logic [16:0] o_xp_r, o_yp_r, o_wp_r, o_bp_r;
  logic [15:0] o_xw_r, o_yw_r, o_ww_r, o_bn_r;

  assign in_if.ready = (st_r == ST_IDLE);
  assign in_take     = in_if.valid && in_if.ready;
  assign emit_load   = (st_r == ST_EMIT) && (!out_valid_r || out_if.ready);

  hdmlp_item_dec u_dec (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (in_take),
    .clr     (emit_load),
    .byte_in (in_if.desc_byte),
    .item    (item)
  );

  hdmlp_ram #(.WIDTH(16), .DEPTH(USAGE_SLOTS)) u_usage_ram (
    .clk(clk), .we(u_we), .waddr(u_waddr), .wdata(item.value[15:0]),
    .raddr(u_raddr), .rdata(u_rdata)
  );

  hdmlp_ram #(.WIDTH(16), .DEPTH(REPORT_IDS)) u_ofs_ram (
    .clk(clk), .we(o_we), .waddr(ofs_idx_r), .wdata(o_wdata),
    .raddr(o_raddr), .rdata(o_rdata)
  );

  // Usage selection for the field under walk
  assign wi_lt_fill = wi_r < 16'(fill_r);
  assign u_raddr    = wi_lt_fill ? wi_r[UA_W-1:0] : UA_W'(fill_r - FILL_W'(1));
  assign o_raddr    = id_index(id_r);
  assign pos_sum    = {1'b0, pos_r} + {1'b0, size_r};
  assign wi_inc     = {1'b0, wi_r} + 17'd1;
  assign ofs_sum    = {17'd0, base_r} + {1'b0, prod_r};
  assign o_wdata    = sat16(ofs_sum);
  assign o_we       = (st_r == ST_FINISH);
  assign u_waddr    = fill_r[UA_W-1:0];
  assign u_we       = in_take && item.done && item.kind == ITEM_LOCAL &&
                      item.tag == TAG_USAGE && fill_r < FILL_W'(USAGE_SLOTS);

  always_comb begin
    if (wi_lt_fill) begin
      usage = u_rdata;
    end else if (rng_seen_r && rng_lo_r <= rng_hi_r) begin
      usage = rng_lo_r + wi_r;
    end else if (fill_r != '0) begin
      usage = u_rdata;
    end else begin
      usage = '0;
    end
  end

  // Main control
  always_comb begin
    st_nxt = st_r;
    page_nxt = page_r; size_nxt = size_r; count_nxt = count_r; id_nxt = id_r;
    uses_id_nxt = uses_id_r; fill_nxt = fill_r; rng_seen_nxt = rng_seen_r;
    rng_lo_nxt = rng_lo_r; rng_hi_nxt = rng_hi_r; last_pend_nxt = last_pend_r;
    const_nxt = const_r; ofs_idx_nxt = ofs_idx_r; ofs_vld_nxt = ofs_vld_r;
    base_nxt = base_r; pos_nxt = pos_r; wi_nxt = wi_r; wn_nxt = wn_r; prod_nxt = prod_r;
    x_pos_nxt = x_pos_r; x_w_nxt = x_w_r; x_f_nxt = x_f_r;
    y_pos_nxt = y_pos_r; y_w_nxt = y_w_r; y_f_nxt = y_f_r;
    wh_pos_nxt = wh_pos_r; wh_w_nxt = wh_w_r; wh_f_nxt = wh_f_r;
    bt_pos_nxt = bt_pos_r; bt_n_nxt = bt_n_r; bt_f_nxt = bt_f_r;
    rid_nxt = rid_r;

    case (st_r)
      ST_IDLE: begin
        if (in_take) begin
          last_pend_nxt = in_if.last_byte;
          if (in_if.last_byte) st_nxt = ST_EMIT;
          if (item.done) begin
            case (item.kind)
              ITEM_GLOBAL: begin
                case (item.tag)
                  TAG_USAGE_PAGE:   page_nxt = item.value[15:0];
                  TAG_REPORT_SIZE:  size_nxt = sat16({1'b0, item.value});
                  TAG_REPORT_COUNT: count_nxt = sat16({1'b0, item.value});
                  TAG_REPORT_ID: begin
                    id_nxt = item.value[7:0];
                    uses_id_nxt = 1'b1;
                  end
                  default: ;
                endcase
              end
              ITEM_LOCAL: begin
                case (item.tag)
                  TAG_USAGE: if (u_we) fill_nxt = fill_r + FILL_W'(1);
                  TAG_USAGE_MIN: begin
                    rng_lo_nxt = item.value[15:0];
                    rng_seen_nxt = 1'b1;
                  end
                  TAG_USAGE_MAX: begin
                    rng_hi_nxt = item.value[15:0];
                    rng_seen_nxt = 1'b1;
                  end
                  default: ;
                endcase
              end
              ITEM_MAIN: begin
                if (item.tag == TAG_INPUT) begin
                  ofs_idx_nxt = o_raddr;
                  const_nxt = item.value[0];
                  st_nxt = ST_BASE;
                end else begin
                  fill_nxt = '0; rng_seen_nxt = 1'b0; rng_lo_nxt = '0; rng_hi_nxt = '0;
                end
              end
              default: ;
            endcase
          end
        end
      end
      // Offset read returns; set up the walk
      ST_BASE: begin
        base_nxt = ofs_vld_r[ofs_idx_r] ? o_rdata : 16'd0;
        pos_nxt  = base_nxt;
        prod_nxt = size_r * count_r;
        wi_nxt   = '0;
        wn_nxt   = (count_r < MAX_F) ? count_r : MAX_F;
        st_nxt   = (!const_r && size_r != '0 && count_r != '0) ? ST_WALK_RD : ST_FINISH;
      end
      ST_WALK_RD: st_nxt = ST_WALK_EV;
      // Classify one field
      ST_WALK_EV: begin
        if (page_r == PAGE_DESKTOP && usage == USAGE_X) begin
          rid_nxt = id_r; x_pos_nxt = pos_r; x_w_nxt = size_r; x_f_nxt = 1'b1;
        end else if (page_r == PAGE_DESKTOP && usage == USAGE_Y) begin
          rid_nxt = id_r; y_pos_nxt = pos_r; y_w_nxt = size_r; y_f_nxt = 1'b1;
        end else if (page_r == PAGE_DESKTOP && usage == USAGE_WHEEL) begin
          wh_pos_nxt = pos_r; wh_w_nxt = size_r; wh_f_nxt = 1'b1;
        end else if (page_r == PAGE_BUTTON && !bt_f_r) begin
          rid_nxt = id_r; bt_pos_nxt = pos_r; bt_n_nxt = count_r; bt_f_nxt = 1'b1;
        end
        pos_nxt = pos_sum[16] ? SAT_MAX : pos_sum[15:0];
        wi_nxt  = wi_inc[15:0];
        st_nxt  = (wi_inc == {1'b0, wn_r}) ? ST_FINISH : ST_WALK_RD;
      end
      // Store the advanced offset, drop locals
      ST_FINISH: begin
        ofs_vld_nxt[ofs_idx_r] = 1'b1;
        fill_nxt = '0; rng_seen_nxt = 1'b0; rng_lo_nxt = '0; rng_hi_nxt = '0;
        st_nxt = last_pend_r ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (emit_load) begin
          st_nxt = ST_IDLE;
          page_nxt = '0; size_nxt = '0; count_nxt = '0; id_nxt = '0; uses_id_nxt = 1'b0;
          fill_nxt = '0; rng_seen_nxt = 1'b0; rng_lo_nxt = '0; rng_hi_nxt = '0;
          last_pend_nxt = 1'b0; ofs_vld_nxt = '0;
          x_w_nxt = '0; y_w_nxt = '0; wh_w_nxt = '0; bt_n_nxt = '0;
          x_f_nxt = 1'b0; y_f_nxt = 1'b0; wh_f_nxt = 1'b0; bt_f_nxt = 1'b0;
          rid_nxt = '0;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Control and parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      page_r <= '0; size_r <= '0; count_r <= '0; id_r <= '0; uses_id_r <= 1'b0;
      fill_r <= '0; rng_seen_r <= 1'b0; rng_lo_r <= '0; rng_hi_r <= '0;
      last_pend_r <= 1'b0; const_r <= 1'b0; ofs_idx_r <= '0; ofs_vld_r <= '0;
      wi_r <= '0; wn_r <= '0;
      x_w_r <= '0; y_w_r <= '0; wh_w_r <= '0; bt_n_r <= '0;
      x_f_r <= 1'b0; y_f_r <= 1'b0; wh_f_r <= 1'b0; bt_f_r <= 1'b0;
      rid_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      page_r <= page_nxt; size_r <= size_nxt; count_r <= count_nxt; id_r <= id_nxt;
      uses_id_r <= uses_id_nxt; fill_r <= fill_nxt; rng_seen_r <= rng_seen_nxt;
      rng_lo_r <= rng_lo_nxt; rng_hi_r <= rng_hi_nxt; last_pend_r <= last_pend_nxt;
      const_r <= const_nxt; ofs_idx_r <= ofs_idx_nxt; ofs_vld_r <= ofs_vld_nxt;
      wi_r <= wi_nxt; wn_r <= wn_nxt;
      x_w_r <= x_w_nxt; y_w_r <= y_w_nxt; wh_w_r <= wh_w_nxt; bt_n_r <= bt_n_nxt;
      x_f_r <= x_f_nxt; y_f_r <= y_f_nxt; wh_f_r <= wh_f_nxt; bt_f_r <= bt_f_nxt;
      rid_r <= rid_nxt;
      if (emit_load) out_valid_r <= 1'b1;
      else if (out_if.ready) out_valid_r <= 1'b0;
    end
  end

  // Datapath and result payload
  always_ff @(posedge clk) begin
    base_r <= base_nxt; pos_r <= pos_nxt; prod_r <= prod_nxt;
    x_pos_r <= x_pos_nxt; y_pos_r <= y_pos_nxt; wh_pos_r <= wh_pos_nxt; bt_pos_r <= bt_pos_nxt;
    if (emit_load) begin
      o_lv_r   <= x_f_r && y_f_r;
      o_rid_r  <= rid_r;
      o_uses_r <= uses_id_r;
      o_xp_r   <= x_f_r ? {1'b0, x_pos_r} : POS_ABSENT;
      o_xw_r   <= x_w_r;
      o_yp_r   <= y_f_r ? {1'b0, y_pos_r} : POS_ABSENT;
      o_yw_r   <= y_w_r;
      o_wp_r   <= wh_f_r ? {1'b0, wh_pos_r} : POS_ABSENT;
      o_ww_r   <= wh_w_r;
      o_bp_r   <= bt_f_r ? {1'b0, bt_pos_r} : POS_ABSENT;
      o_bn_r   <= bt_n_r;
    end
  end

  assign out_if.valid            = out_valid_r;
  assign out_if.layout_valid     = o_lv_r;
  assign out_if.layout_report_id = o_rid_r;
  assign out_if.uses_report_id   = o_uses_r;
  assign out_if.x_position       = o_xp_r;
  assign out_if.x_width          = o_xw_r;
  assign out_if.y_position       = o_yp_r;
  assign out_if.y_width          = o_yw_r;
  assign out_if.wheel_position   = o_wp_r;
  assign out_if.wheel_width      = o_ww_r;
  assign out_if.buttons_position = o_bp_r;
  assign out_if.buttons_number   = o_bn_r;
endmodule

// ===== hw/rtl/hdmlp_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks on the layout result channel, bound to the top level.
// Depends on hid_descriptor_mouse_layout_parser_top and hdmlp_pkg.
module hdmlp_checker
  import hdmlp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        layout_valid,
  input logic [16:0] x_position,
  input logic [15:0] x_width,
  input logic [16:0] y_position,
  input logic [16:0] buttons_position,
  input logic [15:0] buttons_number
);
  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(x_position) && $stable(layout_valid))
    else $error("result changed while stalled");

  // Valid layout needs both axes
  a_axes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && layout_valid |-> x_position != POS_ABSENT && y_position != POS_ABSENT)
    else $error("layout valid without X and Y");

  // Missing X carries no width
  a_xw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && x_position == POS_ABSENT |-> x_width == 16'd0)
    else $error("absent X with nonzero width");

  // Missing buttons carry no count
  a_bt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && buttons_position == POS_ABSENT |-> buttons_number == 16'd0)
    else $error("absent buttons with nonzero count");
endmodule

bind hid_descriptor_mouse_layout_parser_top hdmlp_checker u_hdmlp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_if.valid),
  .out_ready        (out_if.ready),
  .layout_valid     (out_if.layout_valid),
  .x_position       (out_if.x_position),
  .x_width          (out_if.x_width),
  .y_position       (out_if.y_position),
  .buttons_position (out_if.buttons_position),
  .buttons_number   (out_if.buttons_number)
);
